// File: rtl/rgbhl_pkg.sv
// Package for the RGB hue and luma converter.
// Holds the pixel, result and internal work word types and the hue and luma constants.
// No dependencies.
package rgbhl_pkg;

	localparam int QBITS = 12;
	localparam int NUM_W = 20;
	localparam int HUE_W = 15;
	localparam int LUMA_W = 18;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [HUE_W-1:0] HUE_RED_POS = 15'd0;
	localparam logic [HUE_W-1:0] HUE_RED_NEG = 15'd19200;
	localparam logic [HUE_W-1:0] HUE_GRN_POS = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_GRN_NEG = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_BLU_POS = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_BLU_NEG = 15'd11520;

	localparam logic [LUMA_W-1:0] LUMA_KR = 18'd299;
	localparam logic [LUMA_W-1:0] LUMA_KG = 18'd587;
	localparam logic [LUMA_W-1:0] LUMA_KB = 18'd114;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue_q6;
		logic [LUMA_W-1:0] luma_weighted;
		logic              achromatic;
	} result_t;

	typedef struct packed {
		logic [HUE_W-1:0]  base;
		logic [LUMA_W-1:0] luma;
		logic              gray;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [7:0]       den;
		side_t            side;
	} work_t;

endpackage

// File: rtl/rgbhl_front.sv
// Front stage: accepts pixels, finds max/min and hue sector, forms the
// divider numerator and the weighted luma. Depends on rgbhl_pkg.
module rgbhl_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_stall,
	input  rgbhl_pkg::pixel_t pix,
	output logic            wrk_valid,
	input  logic            wrk_stall,
	output rgbhl_pkg::work_t wrk
);
	import rgbhl_pkg::*;

	logic [7:0]        mx, mn, d, pos, neg, u;
	logic [HUE_W-1:0]  base_pos, base_neg;
	logic [11:0]       u15;
	work_t             calc;
	logic              vld_s1;
	work_t             wrk_s1;

	always_comb begin
		mx = pix.red;
		mn = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		d = mx - mn;
		priority if (pix.red >= pix.green && pix.red >= pix.blue) begin
			pos = pix.green;
			neg = pix.blue;
			base_pos = HUE_RED_POS;
			base_neg = HUE_RED_NEG;
		end else if (pix.green >= pix.blue) begin
			pos = pix.blue;
			neg = pix.red;
			base_pos = HUE_GRN_POS;
			base_neg = HUE_GRN_NEG;
		end else begin
			pos = pix.red;
			neg = pix.green;
			base_pos = HUE_BLU_POS;
			base_neg = HUE_BLU_NEG;
		end
		if (pos >= neg) begin
			u = pos - neg;
			calc.side.base = base_pos;
		end else begin
			u = d - (neg - pos);
			calc.side.base = base_neg;
		end
		u15 = {u, 4'b0000} - {4'b0000, u};
		calc.num = {u15, 8'b0000_0000};
		calc.den = d;
		calc.side.gray = (d == 8'd0);
		calc.side.luma = LUMA_KR * LUMA_W'(pix.red) + LUMA_KG * LUMA_W'(pix.green)
			+ LUMA_KB * LUMA_W'(pix.blue);
	end

	assign pix_stall = vld_s1 && wrk_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!pix_stall) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pix_stall && pix_valid) begin
			wrk_s1 <= calc;
		end
	end

	assign wrk_valid = vld_s1;
	assign wrk = wrk_s1;

endmodule

// File: rtl/rgbhl_queue.sv
// Short queue of work words between the front and the divider back end.
// Depends on rgbhl_pkg.
module rgbhl_queue #(
	parameter int DEPTH = rgbhl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  rgbhl_pkg::work_t wr_word,
	output logic             rd_valid,
	input  logic             rd_stall,
	output rgbhl_pkg::work_t rd_word
);
	import rgbhl_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	work_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign wr_stall = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_word = mem_q[rd_ptr_q];
	assign push = wr_valid && !wr_stall;
	assign pop = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

endmodule

// File: rtl/rgbhl_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage,
// then hue offset add and result register. Depends on rgbhl_pkg.
module rgbhl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wrk_valid,
	output logic              wrk_stall,
	input  rgbhl_pkg::work_t  wrk,
	output logic              res_valid,
	input  logic              res_stall,
	output rgbhl_pkg::result_t res
);
	import rgbhl_pkg::*;

	logic              en;
	logic [QBITS:1]    vld_s;
	logic [NUM_W-1:0]  rem_s [1:QBITS];
	logic [QBITS-1:0]  quo_s [1:QBITS];
	logic [7:0]        den_s [1:QBITS];
	side_t             side_s [1:QBITS];

	logic [NUM_W-1:0]  src_rem [QBITS];
	logic [QBITS-1:0]  src_quo [QBITS];
	logic [7:0]        src_den [QBITS];
	side_t             src_side [QBITS];
	logic              src_vld [QBITS];
	logic [NUM_W-1:0]  nxt_rem [QBITS];
	logic [QBITS-1:0]  nxt_quo [QBITS];
	logic [NUM_W-1:0]  dsr [QBITS];

	logic              res_vld_q;
	result_t           res_q;

	assign en = !(res_vld_q && res_stall);
	assign wrk_stall = !en;

	always_comb begin
		src_rem[0] = wrk.num;
		src_quo[0] = '0;
		src_den[0] = wrk.den;
		src_side[0] = wrk.side;
		src_vld[0] = wrk_valid;
		for (int k = 1; k < QBITS; k++) begin
			src_rem[k] = rem_s[k];
			src_quo[k] = quo_s[k];
			src_den[k] = den_s[k];
			src_side[k] = side_s[k];
			src_vld[k] = vld_s[k];
		end
		for (int k = 0; k < QBITS; k++) begin
			dsr[k] = NUM_W'(src_den[k]) << (QBITS - 1 - k);
			if (src_rem[k] >= dsr[k]) begin
				nxt_rem[k] = src_rem[k] - dsr[k];
				nxt_quo[k] = src_quo[k] | (QBITS'(1) << (QBITS - 1 - k));
			end else begin
				nxt_rem[k] = src_rem[k];
				nxt_quo[k] = src_quo[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < QBITS; k++) begin
				vld_s[k+1] <= src_vld[k];
			end
			res_vld_q <= vld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QBITS; k++) begin
				rem_s[k+1] <= nxt_rem[k];
				quo_s[k+1] <= nxt_quo[k];
				den_s[k+1] <= src_den[k];
				side_s[k+1] <= src_side[k];
			end
			res_q.hue_q6 <= side_s[QBITS].gray ? '0
				: side_s[QBITS].base + HUE_W'(quo_s[QBITS]);
			res_q.luma_weighted <= side_s[QBITS].luma;
			res_q.achromatic <= side_s[QBITS].gray;
		end
	end

	assign res_valid = res_vld_q;
	assign res = res_q;

endmodule

// File: rtl/rgb_to_hue_and_luma_core.sv
// RGB to HSV hue and Rec.601 weighted luma, one pixel word per cycle when not stalled.
// Path from pixel accept to result valid: front register, queue,
// 12-stage divider (one quotient bit per stage), result register.
// Throughput one word per cycle when res_stall does not hold the flow, set by the pipelined restoring divider.
// Reset clears all valid flags and queue pointers; no state survives a word.
// Depends on rgbhl_pkg, rgbhl_front, rgbhl_queue, rgbhl_back.
module rgb_to_hue_and_luma_core #(
	parameter int QUEUE_DEPTH = rgbhl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  rgbhl_pkg::pixel_t  pix,
	output logic               res_valid,
	input  logic               res_stall,
	output rgbhl_pkg::result_t res
);
	import rgbhl_pkg::*;

	logic  f_valid, f_stall, q_valid, q_stall;
	work_t f_word, q_word;

	rgbhl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.wrk_valid (f_valid),
		.wrk_stall (f_stall),
		.wrk       (f_word)
	);

	rgbhl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_word  (f_word),
		.rd_valid (q_valid),
		.rd_stall (q_stall),
		.rd_word  (q_word)
	);

	rgbhl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wrk_valid (q_valid),
		.wrk_stall (q_stall),
		.wrk       (q_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
